// File: sv/lpac_pkg.sv
// ----------------------------------------------------------------------------
// Layered pixel compositor package
// Shared widths, codes, reset values and pixel helpers.
// ----------------------------------------------------------------------------
package lpac_pkg;

  // Default sizes of the layer stores.
  localparam int unsigned LayersDef     = 4;
  localparam int unsigned SurfWidthDef  = 64;
  localparam int unsigned SurfHeightDef = 64;

  // Field widths.
  localparam int unsigned PosW      = 12;
  localparam int unsigned PixW      = 32;
  localparam int unsigned LayerW    = 4;
  localparam int unsigned TopW      = 2;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned DispIdxW  = 24;
  localparam int unsigned SurfDimW  = 7;
  localparam int unsigned DispWidW  = 13;
  localparam int unsigned CountW    = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 13;

  // Configuration reset values.
  localparam logic [SurfDimW-1:0] SurfWidthRst  = 7'd64;
  localparam logic [SurfDimW-1:0] SurfHeightRst = 7'd64;
  localparam logic [TopW-1:0]     MaxLayerRst   = 2'd3;
  localparam logic [DispWidW-1:0] DispWidthRst  = 13'd64;
  localparam logic                DispWideRst   = 1'b1;

  typedef logic [PixW-1:0] pixel_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SURFACE_WIDTH  = 3'd0,
    CFG_SURFACE_HEIGHT = 3'd1,
    CFG_MAX_LAYER      = 3'd2,
    CFG_DISPLAY_WIDTH  = 3'd3,
    CFG_DISPLAY_WIDE   = 3'd4
  } cfg_idx_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OUTSIDE   = 2'd1,
    STATUS_BAD_LAYER = 2'd2
  } status_e;

  // Packs the color channels of an ARGB pixel into RGB565.
  function automatic logic [15:0] to_rgb565(input pixel_t pix);
    return {pix[23:19], pix[15:10], pix[7:3]};
  endfunction

endpackage

// File: sv/lpac_if.sv
// ----------------------------------------------------------------------------
// Layered pixel compositor channels
// Valid/ready channels for pixel write items and result items.
// ----------------------------------------------------------------------------
interface lpac_in_if;
  import lpac_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [PosW-1:0]   pos_x;
  logic signed [PosW-1:0]   pos_y;
  logic [PixW-1:0]          colour;
  logic [LayerW-1:0]        layer;

  modport source (output valid, pos_x, pos_y, colour, layer, input ready);
  modport sink   (input valid, pos_x, pos_y, colour, layer, output ready);
endinterface

interface lpac_out_if;
  import lpac_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [StatusW-1:0]   status;
  logic [DispIdxW-1:0]  display_index;
  logic [PixW-1:0]      display_pixel;
  logic                 pixel_wide;

  modport source (output valid, status, display_index, display_pixel, pixel_wide,
                  input ready);
  modport sink   (input valid, status, display_index, display_pixel, pixel_wide,
                  output ready);
endinterface

// File: sv/lpac_layer_mem.sv
// ----------------------------------------------------------------------------
// Layer store memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lpac_layer_mem #(
  parameter int unsigned Depth = 16384,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  lpac_pkg::pixel_t     wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output lpac_pkg::pixel_t     rdata_o
);
  import lpac_pkg::*;

  pixel_t mem_q [Depth];
  pixel_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/lpac_blend.sv
// ----------------------------------------------------------------------------
// Alpha blend unit
// Blends an upper pixel over a lower one; products are registered, then
// summed and divided by 255.
// ----------------------------------------------------------------------------
module lpac_blend (
  input  logic              clk_i,
  input  logic              en_i,
  input  lpac_pkg::pixel_t  up_i,
  input  lpac_pkg::pixel_t  lo_i,
  output lpac_pkg::pixel_t  pix_o
);
  import lpac_pkg::*;

  logic [7:0]  alpha;
  logic [7:0]  alpha_inv;
  logic [7:0]  chan      [3];

  assign alpha     = up_i[31:24];
  assign alpha_inv = 8'hFF - alpha;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [15:0] up_prod_q;
    logic [15:0] lo_prod_q;
    logic [16:0] sum;
    logic [16:0] quot;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        up_prod_q <= up_i[8*c +: 8] * alpha;
        lo_prod_q <= lo_i[8*c +: 8] * alpha_inv;
      end
    end

    // The sum never exceeds 255*255, where (s + s/256 + 1)/256 equals s/255.
    assign sum  = {1'b0, up_prod_q} + {1'b0, lo_prod_q};
    assign quot = (sum + {8'b0, sum[16:8]} + 17'd1) >> 8;
    assign chan[c] = quot[7:0];
  end

  assign pix_o = {8'hFF, chan[2], chan[1], chan[0]};

endmodule

// File: sv/layered_pixel_alpha_compositor_core.sv
// ----------------------------------------------------------------------------
// Layered pixel alpha compositor
// Stores pixel writes into per-layer surfaces and blends the next layer up
// over each new pixel, producing a display index and display pixel.
// ----------------------------------------------------------------------------
// Usage:
// Pixel write items enter on in_i (pos_x, pos_y, colour, layer) and one
// result item leaves on out_o for every accepted item, in order. An item is
// moved on a channel at a rising edge where valid and ready are both high.
// The configuration port writes one register per cycle in which cfg_we_i is
// high; it is meant to be written only while no item is in flight.
// Each item walks through four steps: address calculation at acceptance,
// the layer store access (write of the new pixel, read of the layer above),
// the blend multiplies, and the division plus formatting into the output
// register. The block works on one item at a time: a new item is taken
// only after the last one has been loaded into the output register.
// After reset the block sweeps all LAYERS*SURF_WIDTH*SURF_HEIGHT words of
// the layer store (16384 with the defaults) to zero, one word per cycle;
// in_i.ready stays low during the sweep while configuration writes are taken.
// When the receiver stalls, the finished result waits in the output register
// and the next item is still accepted and worked on until it needs that
// register.
// ----------------------------------------------------------------------------
module layered_pixel_alpha_compositor_core #(
  parameter int unsigned LAYERS      = lpac_pkg::LayersDef,
  parameter int unsigned SURF_WIDTH  = lpac_pkg::SurfWidthDef,
  parameter int unsigned SURF_HEIGHT = lpac_pkg::SurfHeightDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lpac_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lpac_pkg::CfgDataW-1:0]  cfg_data_i,
  lpac_in_if.sink                        in_i,
  lpac_out_if.source                     out_o
);
  import lpac_pkg::*;

  localparam int unsigned LayerWords = SURF_WIDTH * SURF_HEIGHT;
  localparam int unsigned Depth      = LAYERS * LayerWords;
  localparam int unsigned AddrW      = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned OffW       = 2 * SurfDimW + 1;

  // One-hot sequencer states.
  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_ACCESS = 5'b00100,
    ST_MUL    = 5'b01000,
    ST_OUT    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [SurfDimW-1:0] surface_width_q, surface_height_q;
  logic [TopW-1:0]     max_layer_q;
  logic [DispWidW-1:0] display_width_q;
  logic                display_wide_q;

  // Block state held in flops.
  logic [TopW-1:0]   top_layer_q;
  logic [CountW-1:0] write_count_q;
  logic [AddrW-1:0]  clr_addr_q;

  // Item registers.
  status_e             status_q;
  logic [OffW-1:0]     off_q;
  logic [DispIdxW-1:0] disp_idx_q;
  pixel_t              colour_q;
  logic [TopW-1:0]     layer_q;
  logic                blend_q;

  // Output register.
  logic                out_valid_q;
  status_e             out_status_q;
  logic [DispIdxW-1:0] out_idx_q;
  pixel_t              out_pix_q;
  logic                out_wide_q;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surface_width_q  <= SurfWidthRst;
      surface_height_q <= SurfHeightRst;
      max_layer_q      <= MaxLayerRst;
      display_width_q  <= DispWidthRst;
      display_wide_q   <= DispWideRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SURFACE_WIDTH:  surface_width_q  <= cfg_data_i[SurfDimW-1:0];
        CFG_SURFACE_HEIGHT: surface_height_q <= cfg_data_i[SurfDimW-1:0];
        CFG_MAX_LAYER:      max_layer_q      <= cfg_data_i[TopW-1:0];
        CFG_DISPLAY_WIDTH:  display_width_q  <= cfg_data_i[DispWidW-1:0];
        CFG_DISPLAY_WIDE:   display_wide_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Acceptance: range checks, surface offset and display index
  // ---------------------------------------------------------------------------
  logic [SurfDimW-1:0]   w_eff, h_eff;
  logic                  in_surface, layer_ok, accept;
  logic [SurfDimW-1:0]   ux, uy;
  logic [2*SurfDimW-1:0] row_off;
  logic [OffW-1:0]       off;
  logic [DispIdxW-1:0]   disp_idx;

  // The effective size is the register clipped to the store's dimension.
  assign w_eff = (32'(surface_width_q) < SURF_WIDTH) ? surface_width_q
                                                     : SurfDimW'(SURF_WIDTH);
  assign h_eff = (32'(surface_height_q) < SURF_HEIGHT) ? surface_height_q
                                                       : SurfDimW'(SURF_HEIGHT);

  assign in_surface = !in_i.pos_x[PosW-1] && !in_i.pos_y[PosW-1] &&
                      (in_i.pos_x[PosW-2:0] < (PosW-1)'(w_eff)) &&
                      (in_i.pos_y[PosW-2:0] < (PosW-1)'(h_eff));
  assign layer_ok   = (in_i.layer <= LayerW'(max_layer_q)) &&
                      (32'(in_i.layer) < LAYERS);

  // Within the surface both coordinates fit the narrow size width.
  assign ux       = in_i.pos_x[SurfDimW-1:0];
  assign uy       = in_i.pos_y[SurfDimW-1:0];
  assign row_off  = uy * w_eff;
  assign off      = OffW'(row_off) + OffW'(ux);
  assign disp_idx = DispIdxW'(uy) * DispIdxW'(display_width_q) + DispIdxW'(ux);

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      off_q      <= off;
      disp_idx_q <= disp_idx;
      colour_q   <= in_i.colour;
      layer_q    <= in_i.layer[TopW-1:0];
    end
  end

  // Status is control: it decides whether the store is written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= STATUS_OK;
    end else if (accept) begin
      if (!in_surface) begin
        status_q <= STATUS_OUTSIDE;
      end else if (!layer_ok) begin
        status_q <= STATUS_BAD_LAYER;
      end else begin
        status_q <= STATUS_OK;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Layer store access
  // ---------------------------------------------------------------------------
  logic             item_wr;
  logic             blend;
  logic [AddrW-1:0] layer_base, item_addr;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  pixel_t           mem_wdata, mem_rdata;

  assign item_wr    = (state_q == ST_ACCESS) && (status_q == STATUS_OK);
  // The layer above is in use exactly when this item's layer lies below the
  // highest layer written so far, before this write raises that mark.
  assign blend      = (layer_q < top_layer_q);
  assign layer_base = AddrW'(layer_q) * AddrW'(LayerWords);
  assign item_addr  = layer_base + AddrW'(off_q);

  assign mem_we    = (state_q == ST_CLEAR) || item_wr;
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_addr_q : item_addr;
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : colour_q;
  assign mem_re    = item_wr && blend;
  assign mem_raddr = item_addr + AddrW'(LayerWords);

  lpac_layer_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_layer_q   <= '0;
      write_count_q <= '0;
      blend_q       <= 1'b0;
      clr_addr_q    <= '0;
    end else begin
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
      end
      if (state_q == ST_ACCESS) begin
        blend_q <= item_wr && blend;
      end
      if (item_wr) begin
        write_count_q <= write_count_q + CountW'(1);
        if (layer_q > top_layer_q) begin
          top_layer_q <= layer_q;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Blend and output
  // ---------------------------------------------------------------------------
  pixel_t blend_pix, pix;

  lpac_blend u_blend (
    .clk_i (clk_i),
    .en_i  (state_q == ST_MUL),
    .up_i  (mem_rdata),
    .lo_i  (colour_q),
    .pix_o (blend_pix)
  );

  logic out_load;

  assign pix      = blend_q ? blend_pix : colour_q;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_status_q <= STATUS_OK;
    end else if (out_load) begin
      out_valid_q  <= 1'b1;
      out_status_q <= status_q;
    end else if (out_o.ready) begin
      out_valid_q  <= 1'b0;
    end
  end

  // Rejected items report zero in every field but the status.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (status_q != STATUS_OK) begin
        out_idx_q  <= '0;
        out_pix_q  <= '0;
        out_wide_q <= 1'b0;
      end else begin
        out_idx_q  <= disp_idx_q;
        out_pix_q  <= display_wide_q ? pix : {16'b0, to_rgb565(pix)};
        out_wide_q <= display_wide_q;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.display_index = out_idx_q;
  assign out_o.display_pixel = out_pix_q;
  assign out_o.pixel_wide    = out_wide_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == AddrW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_ACCESS;
        end
      end
      ST_ACCESS: state_d = ST_MUL;
      ST_MUL:    state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_wr |=> write_count_q == $past(write_count_q) + CountW'(1))
    else $error("write count did not follow a layer store write");

  a_rejected_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q != STATUS_OK) |->
      (out_idx_q == '0) && (out_pix_q == '0) && !out_wide_q)
    else $error("rejected item carries nonzero result fields");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_i.ready)
    else $error("item accepted during the store clearing sweep");

  a_top_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_layer_q >= $past(top_layer_q))
    else $error("highest used layer decreased");

  a_rw_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("layer store read and write hit the same word");

  a_blend_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) && blend_q |-> $past(mem_re))
    else $error("blend uses a layer store word that was not read");

endmodule
